FILE: rtl/uds_pkg.sv
package uds_pkg;

  // Trig magnitudes are Q30 values up to and including 1.0
  localparam int TRIG_W = 31;
  localparam int X2_W   = 30;

  localparam logic [TRIG_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [29:0]       PI4_Q30 = 30'd843314857;

  // Exact floor division of a value below 2^30 by a small constant c:
  // q = (n * M) >> K, M = ceil(2^K / c), K = 30 + ceil(log2 c).
  localparam int D42_K = 36;
  localparam int D20_K = 35;
  localparam int D6_K  = 33;
  localparam int D56_K = 36;
  localparam int D30_K = 35;
  localparam int D12_K = 34;
  localparam int D2_K  = 31;

  localparam logic [30:0] D42_M = 31'(((64'd1 << D42_K) + 64'd41) / 64'd42);
  localparam logic [30:0] D20_M = 31'(((64'd1 << D20_K) + 64'd19) / 64'd20);
  localparam logic [30:0] D6_M  = 31'(((64'd1 << D6_K)  + 64'd5)  / 64'd6);
  localparam logic [30:0] D56_M = 31'(((64'd1 << D56_K) + 64'd55) / 64'd56);
  localparam logic [30:0] D30_M = 31'(((64'd1 << D30_K) + 64'd29) / 64'd30);
  localparam logic [30:0] D12_M = 31'(((64'd1 << D12_K) + 64'd11) / 64'd12);
  localparam logic [30:0] D2_M  = 31'(((64'd1 << D2_K)  + 64'd1)  / 64'd2);

  typedef enum logic [1:0] {
    MODE_SPHERE = 2'd0,
    MODE_HEMI   = 2'd1,
    MODE_COSINE = 2'd2
  } mode_t;

endpackage

FILE: rtl/unit_direction_sampler.sv
// Throughput: one item per cycle; busy stays low, every cycle takes an item.
// Latency is set by the two bit-per-cell square root chains (z, then r).
// Results appear for one cycle with done; the receiver cannot stall.
// Reset (rst, synchronous) clears the item pipeline and the mode register.
module unit_direction_sampler #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [15:0]        uniform_a,
  input  logic [15:0]        uniform_b,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] dir_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);

  localparam int F         = FRAC_BITS;
  localparam int N1        = F;          // root bits of sqrt(v << F)
  localparam int N2        = F + 1;      // root bits of r, r may be 1.0
  localparam int TRIG_LAT  = 11;
  localparam int ROOT_LAT  = 2 * F + 4;
  localparam int TD        = ROOT_LAT - TRIG_LAT;
  localparam int LAT       = ROOT_LAT + 2;
  localparam int SW        = F + 33;
  localparam int ZW        = 42;
  localparam int TW        = uds_pkg::TRIG_W;
  localparam int XW        = uds_pkg::X2_W;

  // Fixed handshake: the pipeline takes an item every cycle.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic [1:0] mode;
  logic       accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= uds_pkg::MODE_SPHERE;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // Item tracking: one strobe bit per pipeline stage
  logic [LAT-1:0] vp;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else begin
      vp <= {vp[LAT-2:0], accept};
    end
  end
  assign done = vp[LAT-1];

  // ---------------------------------------------------------------
  // z path, input stage: v in Q.F, linear z for sphere / hemisphere
  // ---------------------------------------------------------------
  logic [39:0]      ua_ext;
  logic [F-1:0]     v;
  logic [F:0]       two_v;
  logic [F:0]       one_f;
  logic [F:0]       zlin_in;
  logic             zneg_in;
  logic             cos_in;

  always_comb begin
    ua_ext  = {uniform_a, 24'd0};
    v       = F'(ua_ext >> (40 - F));
    two_v   = {v, 1'b0};
    one_f   = {1'b1, {F{1'b0}}};
    cos_in  = (mode != uds_pkg::MODE_SPHERE) && (mode != uds_pkg::MODE_HEMI);
    zneg_in = 1'b0;
    zlin_in = {1'b0, v};
    if (mode == uds_pkg::MODE_SPHERE) begin
      if (two_v < one_f) begin
        zneg_in = 1'b1;
        zlin_in = one_f - two_v;
      end else begin
        zlin_in = two_v - one_f;
      end
    end
  end

  // First root chain: sqrt(v << F) for the cosine-weighted mode
  logic [N1:0]     s1_rem  [0:N1];
  logic [N1-1:0]   s1_root [0:N1];
  logic [2*N1-1:0] s1_rad  [0:N1];
  logic [F:0]      s1_zlin [0:N1];
  logic            s1_zneg [0:N1];
  logic            s1_cos  [0:N1];
  logic [2*N1-1:0] rad1;

  always_ff @(posedge clk) begin
    rad1       <= {v, {F{1'b0}}};
    s1_zlin[0] <= zlin_in;
    s1_zneg[0] <= zneg_in;
    s1_cos[0]  <= cos_in;
    for (int i = 0; i < N1; i++) begin
      s1_zlin[i+1] <= s1_zlin[i];
      s1_zneg[i+1] <= s1_zneg[i];
      s1_cos[i+1]  <= s1_cos[i];
    end
  end

  assign s1_rem[0]  = '0;
  assign s1_root[0] = '0;
  assign s1_rad[0]  = rad1;

  for (genvar i = 0; i < N1; i++) begin : g_root1
    uds_sqrt_cell #(.N(N1)) u_cell (
      .clk      (clk),
      .rem_in   (s1_rem[i]),
      .root_in  (s1_root[i]),
      .rad_in   (s1_rad[i]),
      .rem_out  (s1_rem[i+1]),
      .root_out (s1_root[i+1]),
      .rad_out  (s1_rad[i+1])
    );
  end

  // z select and z*z, then radicand 1 - z*z
  logic [F:0]       zmag_sel;
  logic [F:0]       zmag_a;
  logic             zneg_a;
  logic [2*F+1:0]   zz_a;
  logic [2*F+1:0]   one2;
  logic [2*N2-1:0]  rad2;

  always_comb begin
    zmag_sel = s1_cos[N1] ? {1'b0, s1_root[N1]} : s1_zlin[N1];
    one2     = {2'b01, {(2*F){1'b0}}};
  end

  always_ff @(posedge clk) begin
    zmag_a <= zmag_sel;
    zneg_a <= s1_zneg[N1];
    zz_a   <= (2*F+2)'(zmag_sel) * (2*F+2)'(zmag_sel);
    rad2   <= one2 - zz_a;
  end

  // Second root chain: r = sqrt(1 - z*z)
  logic [N2:0]     s2_rem  [0:N2];
  logic [N2-1:0]   s2_root [0:N2];
  logic [2*N2-1:0] s2_rad  [0:N2];
  logic [F:0]      s2_zmag [0:N2];
  logic            s2_zneg [0:N2];

  assign s2_rem[0]  = '0;
  assign s2_root[0] = '0;
  assign s2_rad[0]  = rad2;

  // z rides along; entry 0 loads with rad2
  always_ff @(posedge clk) begin
    s2_zmag[0] <= zmag_a;
    s2_zneg[0] <= zneg_a;
    for (int i = 0; i < N2; i++) begin
      s2_zmag[i+1] <= s2_zmag[i];
      s2_zneg[i+1] <= s2_zneg[i];
    end
  end

  for (genvar i = 0; i < N2; i++) begin : g_root2
    uds_sqrt_cell #(.N(N2)) u_cell (
      .clk      (clk),
      .rem_in   (s2_rem[i]),
      .root_in  (s2_root[i]),
      .rad_in   (s2_rad[i]),
      .rem_out  (s2_rem[i+1]),
      .root_out (s2_root[i+1]),
      .rad_out  (s2_rad[i+1])
    );
  end

  // ---------------------------------------------------------------
  // Azimuth path: fold to [0, pi/4], Taylor series in Horner cells
  // ---------------------------------------------------------------
  logic [13:0]   g;
  logic          swap_in;
  logic [13:0]   gf;
  logic [XW-1:0] x_a;
  logic          swap_a;
  logic [1:0]    quad_a;
  logic [XW-1:0] x_b;
  logic [XW-1:0] x2_b;
  logic          swap_b;
  logic [1:0]    quad_b;

  always_comb begin
    g       = uniform_b[13:0];
    swap_in = (g > 14'd8192);
    gf      = swap_in ? 14'(15'd16384 - 15'(g)) : g;
  end

  always_ff @(posedge clk) begin
    x_a    <= XW'((44'(gf) * 44'(uds_pkg::PI4_Q30)) >> 13);
    swap_a <= swap_in;
    quad_a <= uniform_b[15:14];
    x_b    <= x_a;
    x2_b   <= XW'((60'(x_a) * 60'(x_a)) >> 30);
    swap_b <= swap_a;
    quad_b <= quad_a;
  end

  // sine: 1 - x2/42, 1 - x2*t/20, 1 - x2*t/6, then x*t
  logic [XW-1:0] sx2_1, sx2_2;
  logic [TW-1:0] st_1, st_2, st_3;
  // cosine: 1 - x2/56, /30, /12, /2
  logic [XW-1:0] cx2_1, cx2_2, cx2_3;
  logic [TW-1:0] ct_1, ct_2, ct_3, ct_4;

  uds_horner_cell #(.DIV_M(uds_pkg::D42_M), .DIV_K(uds_pkg::D42_K)) u_s0 (
    .clk(clk), .x2_in(x2_b), .t_in(uds_pkg::Q30_ONE), .x2_out(sx2_1), .t_out(st_1));
  uds_horner_cell #(.DIV_M(uds_pkg::D20_M), .DIV_K(uds_pkg::D20_K)) u_s1 (
    .clk(clk), .x2_in(sx2_1), .t_in(st_1), .x2_out(sx2_2), .t_out(st_2));
  uds_horner_cell #(.DIV_M(uds_pkg::D6_M), .DIV_K(uds_pkg::D6_K)) u_s2 (
    .clk(clk), .x2_in(sx2_2), .t_in(st_2), .x2_out(), .t_out(st_3));

  uds_horner_cell #(.DIV_M(uds_pkg::D56_M), .DIV_K(uds_pkg::D56_K)) u_c0 (
    .clk(clk), .x2_in(x2_b), .t_in(uds_pkg::Q30_ONE), .x2_out(cx2_1), .t_out(ct_1));
  uds_horner_cell #(.DIV_M(uds_pkg::D30_M), .DIV_K(uds_pkg::D30_K)) u_c1 (
    .clk(clk), .x2_in(cx2_1), .t_in(ct_1), .x2_out(cx2_2), .t_out(ct_2));
  uds_horner_cell #(.DIV_M(uds_pkg::D12_M), .DIV_K(uds_pkg::D12_K)) u_c2 (
    .clk(clk), .x2_in(cx2_2), .t_in(ct_2), .x2_out(cx2_3), .t_out(ct_3));
  uds_horner_cell #(.DIV_M(uds_pkg::D2_M), .DIV_K(uds_pkg::D2_K)) u_c3 (
    .clk(clk), .x2_in(cx2_3), .t_in(ct_3), .x2_out(), .t_out(ct_4));

  // x, fold and quadrant ride alongside the cells
  logic [XW-1:0] xd   [0:5];
  logic          swd  [0:7];
  logic [1:0]    qd   [0:7];
  logic [TW-1:0] s_mul;
  logic [TW-1:0] s_pad;

  always_ff @(posedge clk) begin
    xd[0]  <= x_b;
    swd[0] <= swap_b;
    qd[0]  <= quad_b;
    for (int i = 0; i < 5; i++) begin
      xd[i+1] <= xd[i];
    end
    for (int i = 0; i < 7; i++) begin
      swd[i+1] <= swd[i];
      qd[i+1]  <= qd[i];
    end
    s_mul <= TW'((61'(xd[5]) * 61'(st_3)) >> 30);
    s_pad <= s_mul;
  end

  // Undo the fold, then map the quadrant onto cos/sin magnitude and sign
  logic [TW-1:0] s_f, c_f;
  logic [TW-1:0] cm_next, sm_next;
  logic          cneg_next, sneg_next;
  logic [TW-1:0] cm_t [0:TD];
  logic [TW-1:0] sm_t [0:TD];
  logic          cn_t [0:TD];
  logic          sn_t [0:TD];

  always_comb begin
    s_f = swd[7] ? ct_4 : s_pad;
    c_f = swd[7] ? s_pad : ct_4;
    case (qd[7])
      2'd0: begin
        cm_next = c_f; cneg_next = 1'b0; sm_next = s_f; sneg_next = 1'b0;
      end
      2'd1: begin
        cm_next = s_f; cneg_next = 1'b1; sm_next = c_f; sneg_next = 1'b0;
      end
      2'd2: begin
        cm_next = c_f; cneg_next = 1'b1; sm_next = s_f; sneg_next = 1'b1;
      end
      default: begin
        cm_next = s_f; cneg_next = 1'b0; sm_next = c_f; sneg_next = 1'b1;
      end
    endcase
  end

  // Trig is ready long before r; hold it back to line up
  always_ff @(posedge clk) begin
    cm_t[0] <= cm_next;
    sm_t[0] <= sm_next;
    cn_t[0] <= cneg_next;
    sn_t[0] <= sneg_next;
    for (int i = 0; i < TD; i++) begin
      cm_t[i+1] <= cm_t[i];
      sm_t[i+1] <= sm_t[i];
      cn_t[i+1] <= cn_t[i];
      sn_t[i+1] <= sn_t[i];
    end
  end

  // ---------------------------------------------------------------
  // Scale by r, round half up to Q1.15, then saturate and sign
  // ---------------------------------------------------------------
  logic [N2-1:0] r;
  logic [SW-1:0] px, py;
  logic [ZW-1:0] pz;
  logic [15:0]   xm, ym, zq;
  logic          xneg, yneg, zneg;
  logic          r_zero;

  always_comb begin
    r  = s2_root[N2];
    px = SW'(r) * SW'(cm_t[TD]) + (SW'(1) << (F + 14));
    py = SW'(r) * SW'(sm_t[TD]) + (SW'(1) << (F + 14));
    pz = (ZW'(s2_zmag[N2]) << (40 - F)) + (ZW'(1) << 24);
  end

  always_ff @(posedge clk) begin
    xm     <= 16'(px >> (F + 15));
    ym     <= 16'(py >> (F + 15));
    zq     <= 16'(pz >> 25);
    xneg   <= cn_t[TD];
    yneg   <= sn_t[TD];
    zneg   <= s2_zneg[N2];
    r_zero <= (r == '0);
  end

  function automatic logic [15:0] pack_q15(input logic neg, input logic [15:0] mag);
    logic [15:0] m;
    begin
      if (neg && mag != 16'd0) begin
        m = (mag > 16'd32768) ? 16'd32768 : mag;
        pack_q15 = 16'(17'h10000 - 17'(m));
      end else begin
        pack_q15 = (mag > 16'd32767) ? 16'd32767 : mag;
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    dir_x <= $signed(pack_q15(xneg, xm));
    dir_y <= $signed(pack_q15(yneg, ym));
    dir_z <= $signed(pack_q15(zneg, zq));
  end

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a matching item");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (mode == $past(cfg_data)))
    else $error("mode register missed a write");

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    r_zero |-> (xm == 16'd0 && ym == 16'd0))
    else $error("nonzero x/y with zero radius");
`endif

endmodule

FILE: rtl/uds_sqrt_cell.sv
// One result bit of a restoring integer square root.
module uds_sqrt_cell #(
  parameter int N = 16
) (
  input  logic           clk,
  input  logic [N:0]     rem_in,
  input  logic [N-1:0]   root_in,
  input  logic [2*N-1:0] rad_in,
  output logic [N:0]     rem_out,
  output logic [N-1:0]   root_out,
  output logic [2*N-1:0] rad_out
);

  logic [N+2:0] cur;
  logic [N+2:0] trial;
  logic [N:0]   rem_next;
  logic [N-1:0] root_next;

  always_comb begin
    cur   = {rem_in, rad_in[2*N-1:2*N-2]};
    trial = {1'b0, root_in, 2'b01};
    if (cur >= trial) begin
      rem_next  = (N+1)'(cur - trial);
      root_next = {root_in[N-2:0], 1'b1};
    end else begin
      rem_next  = (N+1)'(cur);
      root_next = {root_in[N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    rem_out  <= rem_next;
    root_out <= root_next;
    rad_out  <= {rad_in[2*N-3:0], 2'b00};
  end

endmodule

FILE: rtl/uds_horner_cell.sv
// One Horner step: t_out = 1 - ((x2 * t_in) >> 30) / c, two stages.
module uds_horner_cell #(
  parameter logic [30:0] DIV_M = 31'd1073741824,
  parameter int          DIV_K = 31
) (
  input  logic                       clk,
  input  logic [uds_pkg::X2_W-1:0]   x2_in,
  input  logic [uds_pkg::TRIG_W-1:0] t_in,
  output logic [uds_pkg::X2_W-1:0]   x2_out,
  output logic [uds_pkg::TRIG_W-1:0] t_out
);

  logic [60:0]                prod;
  logic [60:0]                qprod;
  logic [uds_pkg::X2_W-1:0]   n;
  logic [uds_pkg::X2_W-1:0]   x2_d;
  logic [uds_pkg::TRIG_W-1:0] t_next;

  always_comb begin
    prod   = 61'(x2_in) * 61'(t_in);
    qprod  = 61'(n) * 61'(DIV_M);
    t_next = uds_pkg::Q30_ONE - uds_pkg::TRIG_W'(qprod >> DIV_K);
  end

  always_ff @(posedge clk) begin
    n      <= uds_pkg::X2_W'(prod >> 30);
    x2_d   <= x2_in;
    t_out  <= t_next;
    x2_out <= x2_d;
  end

endmodule
